// ===== design/selective_repeat_receiver_unit_defines.svh =====
// ----------------------------------------------------------------------------
// selective repeat receiver assertion macros
// property shorthands used by the checker file of the receiver
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVER_UNIT_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SRR_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SRR_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/srr_pkg.sv =====
// ----------------------------------------------------------------------------
// srr_pkg
// types and constants of the selective repeat receiver
// ----------------------------------------------------------------------------
package srr_pkg;

	localparam int SEQ_W     = 8;
	localparam int SEQ_SPACE = 256;
	localparam int LEN_W     = 10;
	localparam int WIN_W     = 5;
	localparam int TIME_W    = 32;
	localparam int KIND_W    = 2;
	localparam int MAX_RUN   = 31;
	localparam int RUN_W     = 5;

	typedef enum logic [KIND_W-1:0] {
		KIND_DELIVER = 2'd0,
		KIND_ACK     = 2'd1,
		KIND_NACK    = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIST,
		S_WIN,
		S_RUN_RD,
		S_RUN,
		S_ACK
	} state_t;

	// operands and result of the shared sequence subtractor
	typedef struct packed {
		logic [SEQ_W-1:0] a;
		logic [SEQ_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [SEQ_W-1:0] diff;
		logic             borrow;
	} alu_rsp_t;

endpackage

// ===== design/srr_alu.sv =====
// ----------------------------------------------------------------------------
// srr_alu
// shared modulo-256 subtractor with borrow, used for distance, window
// compare and sequence increment
// ----------------------------------------------------------------------------
module srr_alu (
	input  srr_pkg::alu_req_t req,
	output srr_pkg::alu_rsp_t rsp
);

	logic [srr_pkg::SEQ_W:0] full;

	assign full       = {1'b0, req.a} - {1'b0, req.b};
	assign rsp.diff   = full[srr_pkg::SEQ_W-1:0];
	assign rsp.borrow = full[srr_pkg::SEQ_W];

endmodule

// ===== design/selective_repeat_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_receiver_unit
// receive side of a selective repeat transfer with a reorder buffer of
// payload descriptors and an in-order release sequencer
// ----------------------------------------------------------------------------
// One header is taken per start while busy is low; busy stays high until the
// last result of that header is on the ports. A decode failure is acked after
// the distance step, a duplicate or out-of-window header after the window
// step, and a truncated header is nacked in it. Any other header releases n
// in-order deliveries (at most 31), one per cycle from the reorder memory,
// whose single read port sets that pace, then its ack; a run that reaches 31
// stops without the closing miss. Results are registered, so each comes in the
// cycle after the step that makes it, and is shown for exactly one cycle with
// result_valid; the receiver cannot stall them, so it must take every word as
// it comes. After the end-of-transfer ack a header is taken and dropped.
// window_size must only be written while busy is low.
module selective_repeat_receiver_unit #(
	parameter int REORDER_SLOTS = 32,
	parameter int TAG_BITS      = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       start,
	output logic                       busy,
	input  logic                       decode_ok,
	input  logic                       pkt_kind,
	input  logic                       truncated,
	input  logic [srr_pkg::SEQ_W-1:0]  seq_number,
	input  logic [srr_pkg::LEN_W-1:0]  payload_length,
	input  logic [TAG_BITS-1:0]        payload_tag,
	input  logic [srr_pkg::TIME_W-1:0] now_time,
	output logic                       result_valid,
	output logic [srr_pkg::KIND_W-1:0] result_kind,
	output logic [srr_pkg::SEQ_W-1:0]  seq_number_out,
	output logic [TAG_BITS-1:0]        tag_out,
	output logic [srr_pkg::LEN_W-1:0]  length_out,
	output logic [srr_pkg::WIN_W-1:0]  advertised_window,
	output logic [srr_pkg::TIME_W-1:0] echo_time,
	output logic                       last_of_run,
	output logic                       transfer_done
);

	localparam int SLOT_W = $clog2(REORDER_SLOTS);

	srr_pkg::state_t state_q, state_d;

	logic [srr_pkg::WIN_W-1:0]  window_size_q;
	logic [srr_pkg::SEQ_W-1:0]  last_del_q;
	logic [srr_pkg::SEQ_W-1:0]  nxt_q;
	logic [srr_pkg::SEQ_W-1:0]  final_seq_q;
	logic                       final_known_q;
	logic                       finished_q;
	logic [REORDER_SLOTS-1:0]   valid_q;
	logic [srr_pkg::WIN_W-1:0]  count_q;
	logic [srr_pkg::TIME_W-1:0] last_time_q;
	logic [srr_pkg::RUN_W-1:0]  run_cnt_q;

	logic                       ok_q;
	logic                       fec_q;
	logic                       trunc_q;
	logic [srr_pkg::SEQ_W-1:0]  seq_q;
	logic [srr_pkg::LEN_W-1:0]  len_q;
	logic [TAG_BITS-1:0]        tag_q;
	logic [srr_pkg::TIME_W-1:0] now_q;
	logic [srr_pkg::SEQ_W-1:0]  dist_q;
	logic                       dup_q;

	// reorder memory, one descriptor per slot
	logic [srr_pkg::SEQ_W-1:0]  mem_seq [REORDER_SLOTS];
	logic [TAG_BITS-1:0]        mem_tag [REORDER_SLOTS];
	logic [srr_pkg::LEN_W-1:0]  mem_len [REORDER_SLOTS];
	logic [srr_pkg::SEQ_W-1:0]  rd_seq_q;
	logic [TAG_BITS-1:0]        rd_tag_q;
	logic [srr_pkg::LEN_W-1:0]  rd_len_q;
	logic [SLOT_W-1:0]          rd_slot_q;

	logic                       res_valid_q;
	srr_pkg::kind_t             res_kind_q;
	logic [srr_pkg::SEQ_W-1:0]  res_seq_q;
	logic [TAG_BITS-1:0]        res_tag_q;
	logic [srr_pkg::LEN_W-1:0]  res_len_q;
	logic [srr_pkg::WIN_W-1:0]  res_adv_q;
	logic [srr_pkg::TIME_W-1:0] res_echo_q;
	logic                       res_last_q;
	logic                       res_done_q;

	logic [SLOT_W-1:0]          slot_lut [srr_pkg::SEQ_SPACE];

	srr_pkg::alu_req_t          alu_req;
	srr_pkg::alu_rsp_t          alu_rsp;

	logic                       cfg_wr;
	logic                       rd_en;
	logic [srr_pkg::SEQ_W-1:0]  rd_seq_idx;
	logic [SLOT_W-1:0]          rd_slot;
	logic                       dist_en;
	logic                       store_en;
	logic                       final_en;
	logic                       run_clr;
	logic                       deliver_en;
	logic                       set_fin;
	logic                       emit_en;
	srr_pkg::kind_t             emit_kind;
	logic [srr_pkg::SEQ_W-1:0]  emit_seq;
	logic [TAG_BITS-1:0]        emit_tag;
	logic [srr_pkg::LEN_W-1:0]  emit_len;
	logic [srr_pkg::WIN_W-1:0]  emit_adv;
	logic [srr_pkg::TIME_W-1:0] emit_echo;
	logic                       emit_last;
	logic                       emit_done;
	logic                       inwin;
	logic                       hit;
	logic [srr_pkg::WIN_W-1:0]  cnt_dec;

	function automatic logic [srr_pkg::WIN_W-1:0] adv_of(
		input logic [srr_pkg::WIN_W-1:0] win,
		input logic [srr_pkg::WIN_W-1:0] cnt
	);
		adv_of = (cnt >= win) ? '0 : win - cnt;
	endfunction

	// sequence number to slot, worked out at elaboration
	for (genvar g = 0; g < srr_pkg::SEQ_SPACE; g++) begin : g_slot
		assign slot_lut[g] = SLOT_W'(g % REORDER_SLOTS);
	end

	srr_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && (paddr == 3'd0);
	assign prdata  = (paddr == 3'd0) ? 32'(window_size_q) : '0;
	assign busy    = (state_q != srr_pkg::S_IDLE);
	assign rd_slot = slot_lut[rd_seq_idx];
	assign cnt_dec = (count_q != '0) ? count_q - 5'd1 : '0;

	always_comb begin
		state_d    = state_q;
		alu_req    = '0;
		rd_en      = 1'b0;
		rd_seq_idx = seq_number;
		dist_en    = 1'b0;
		store_en   = 1'b0;
		final_en   = 1'b0;
		run_clr    = 1'b0;
		deliver_en = 1'b0;
		set_fin    = 1'b0;
		emit_en    = 1'b0;
		emit_kind  = srr_pkg::KIND_ACK;
		emit_seq   = nxt_q;
		emit_tag   = '0;
		emit_len   = '0;
		emit_adv   = adv_of(window_size_q, count_q);
		emit_echo  = last_time_q;
		emit_last  = 1'b1;
		emit_done  = 1'b0;
		inwin      = 1'b0;
		hit        = 1'b0;
		case (state_q)
			srr_pkg::S_IDLE: begin
				if (start && !finished_q) begin
					rd_en   = 1'b1;
					state_d = srr_pkg::S_DIST;
				end
			end
			srr_pkg::S_DIST: begin
				alu_req.a = seq_q;
				alu_req.b = last_del_q;
				dist_en   = 1'b1;
				state_d   = ok_q ? srr_pkg::S_WIN : srr_pkg::S_ACK;
			end
			srr_pkg::S_WIN: begin
				// window - dist borrows when the packet lies beyond the window
				alu_req.a = srr_pkg::SEQ_W'(window_size_q);
				alu_req.b = dist_q;
				inwin     = (dist_q != '0) && !alu_rsp.borrow;
				if (!dup_q && inwin) begin
					if (trunc_q) begin
						emit_en   = 1'b1;
						emit_kind = srr_pkg::KIND_NACK;
						emit_seq  = seq_q;
						state_d   = srr_pkg::S_IDLE;
					end else begin
						if (!fec_q && (len_q == '0)) begin
							final_en = 1'b1;
						end else if (!valid_q[rd_slot_q] && (count_q < window_size_q)) begin
							store_en = 1'b1;
						end
						state_d = srr_pkg::S_RUN_RD;
					end
				end else begin
					state_d = srr_pkg::S_ACK;
				end
			end
			srr_pkg::S_RUN_RD: begin
				rd_en      = 1'b1;
				rd_seq_idx = nxt_q;
				run_clr    = 1'b1;
				state_d    = srr_pkg::S_RUN;
			end
			srr_pkg::S_RUN: begin
				alu_req.a = nxt_q;
				alu_req.b = '1;
				hit       = valid_q[rd_slot_q] && (rd_seq_q == nxt_q);
				if (hit) begin
					deliver_en = 1'b1;
					emit_en    = 1'b1;
					emit_kind  = srr_pkg::KIND_DELIVER;
					emit_tag   = rd_tag_q;
					emit_len   = rd_len_q;
					emit_adv   = adv_of(window_size_q, cnt_dec);
					emit_echo  = '0;
					emit_last  = 1'b0;
					// fetch the following slot while this word goes out
					rd_en      = 1'b1;
					rd_seq_idx = alu_rsp.diff;
					if (run_cnt_q == srr_pkg::RUN_W'(srr_pkg::MAX_RUN - 1)) begin
						state_d = srr_pkg::S_ACK;
					end
				end else begin
					state_d = srr_pkg::S_ACK;
				end
			end
			srr_pkg::S_ACK: begin
				emit_en   = 1'b1;
				emit_done = final_known_q && (nxt_q == final_seq_q);
				set_fin   = emit_done;
				state_d   = srr_pkg::S_IDLE;
			end
			default: begin
				state_d = srr_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= 5'd31;
			last_del_q    <= '1;
			nxt_q         <= '0;
			final_seq_q   <= '0;
			final_known_q <= 1'b0;
			finished_q    <= 1'b0;
			valid_q       <= '0;
			count_q       <= '0;
			last_time_q   <= '0;
			run_cnt_q     <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			res_valid_q <= emit_en;
			if (cfg_wr) begin
				window_size_q <= pwdata[srr_pkg::WIN_W-1:0];
			end
			if (final_en) begin
				final_seq_q   <= seq_q;
				final_known_q <= 1'b1;
			end
			if (store_en) begin
				valid_q[rd_slot_q] <= 1'b1;
				count_q            <= count_q + 5'd1;
				last_time_q        <= now_q;
			end
			if (run_clr) begin
				run_cnt_q <= '0;
			end
			if (deliver_en) begin
				valid_q[rd_slot_q] <= 1'b0;
				count_q            <= cnt_dec;
				last_del_q         <= nxt_q;
				nxt_q              <= alu_rsp.diff;
				run_cnt_q          <= run_cnt_q + 5'd1;
			end
			if (set_fin) begin
				finished_q <= 1'b1;
			end
		end
	end

	// header capture and per-item working values
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			ok_q    <= decode_ok;
			fec_q   <= pkt_kind;
			trunc_q <= truncated;
			seq_q   <= seq_number;
			len_q   <= payload_length;
			tag_q   <= payload_tag;
			now_q   <= now_time;
		end
		if (dist_en) begin
			dist_q <= alu_rsp.diff;
			dup_q  <= valid_q[rd_slot_q] && (rd_seq_q == seq_q);
		end
	end

	always_ff @(posedge clk) begin
		if (store_en) begin
			mem_seq[rd_slot_q] <= seq_q;
			mem_tag[rd_slot_q] <= tag_q;
			mem_len[rd_slot_q] <= len_q;
		end
		if (rd_en) begin
			rd_seq_q  <= mem_seq[rd_slot];
			rd_tag_q  <= mem_tag[rd_slot];
			rd_len_q  <= mem_len[rd_slot];
			rd_slot_q <= rd_slot;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			res_kind_q <= emit_kind;
			res_seq_q  <= emit_seq;
			res_tag_q  <= emit_tag;
			res_len_q  <= emit_len;
			res_adv_q  <= emit_adv;
			res_echo_q <= emit_echo;
			res_last_q <= emit_last;
			res_done_q <= emit_done;
		end
	end

	assign result_valid      = res_valid_q;
	assign result_kind       = res_kind_q;
	assign seq_number_out    = res_seq_q;
	assign tag_out           = res_tag_q;
	assign length_out        = res_len_q;
	assign advertised_window = res_adv_q;
	assign echo_time         = res_echo_q;
	assign last_of_run       = res_last_q;
	assign transfer_done     = res_done_q;

endmodule

// ===== design/srr_checker.sv =====
// ----------------------------------------------------------------------------
// srr_checker
// port-level checks of the selective repeat receiver, bound to the top level
// ----------------------------------------------------------------------------
`include "selective_repeat_receiver_unit_defines.svh"

module srr_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       result_valid,
	input logic [srr_pkg::KIND_W-1:0] result_kind,
	input logic                       last_of_run,
	input logic                       transfer_done
);

	// a header never answers in the cycle right after it is taken
	`SRR_ASSERT_NEXT(a_no_early_word, start && !busy, !result_valid, "word right after accept")

	// the closing word of a header is never followed at once by another word
	`SRR_ASSERT_NEXT(a_gap_after_last, result_valid && last_of_run, !result_valid, "word after last")

	// ack and nack always close the answer
	`SRR_ASSERT_NOW(a_ctrl_is_last,
		result_valid && (result_kind != srr_pkg::KIND_DELIVER), last_of_run,
		"ack or nack not last")

	// deliveries only while more words of the same header are due
	`SRR_ASSERT_NOW(a_deliver_busy, result_valid && !last_of_run, busy, "idle mid-run")

	// end of transfer is only flagged on a closing ack
	`SRR_ASSERT_NOW(a_done_on_ack, result_valid && transfer_done,
		(result_kind == srr_pkg::KIND_ACK) && last_of_run, "done on non-ack")

endmodule

bind selective_repeat_receiver_unit srr_checker u_srr_checker (.*);
